[design/keyed_record_table_assert.svh]
// Assertion macros used by the record table RTL.
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/krt_pkg.sv]
// Package of the record table: field widths, request kinds, status codes, record type.
`timescale 1ns / 1ps

package krt_pkg;

	localparam int KRT_DEPTH_DEFAULT = 1024;

	localparam int ID_W    = 31;
	localparam int SAL_W   = 31;
	localparam int DEP_W   = 16;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 3;
	localparam int SLOT_W  = 10;
	localparam int ENTRY_W = 11;
	localparam int REC_W   = ID_W + SAL_W + DEP_W;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_ID   = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] ST_BAD_SLOT = 3'd4;

	localparam logic [ID_W-1:0] ID_MAX = '1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [SAL_W-1:0] salary;
		logic [DEP_W-1:0] dept;
	} record_t;

endpackage

[design/keyed_record_table.sv]
// Top level of the record table: request decode, scan sequencer and result registers.
`timescale 1ns / 1ps

// Keyed record table: a dense, insertion-ordered table of (ID, salary, department).
// Requests: present kind and its operands with start high; the request is taken
// at a rising edge where start is high and busy is low.
// Results: one per request, on status/record_*/entry_count for exactly one cycle
// while done is high. The receiver has no way to stall; sample on that cycle.
// Sequencing, by request kind:
//   load, add, unknown kinds, update/delete on an empty table and a read of a
//   slot at or above the count: result registered at the accepting edge; busy
//   stays low, so these run one request per cycle.
//   read slot in range: one RAM read, then the result register.
//   update and delete: both walk the table, every entry below the count, through
//   the single read port of the record RAM, one entry per cycle; delete moves
//   every entry after the match down one slot as it streams past, so search and
//   compaction share the same pass. Busy holds off the next request until the
//   edge that ends the done cycle, so a read or a scan must finish before the
//   block takes another request.
// Reset clears the count and the last issued ID; the RAM is not cleared, and
// slots are only meaningful once written by a load or an add.
module keyed_record_table import krt_pkg::*; #(
	parameter int TABLE_DEPTH = KRT_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [KIND_W-1:0]  kind,
	input  logic [ID_W-1:0]    key_id,
	input  logic [SAL_W-1:0]   salary_in,
	input  logic [DEP_W-1:0]   department_in,
	input  logic [SLOT_W-1:0]  slot_index,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [ID_W-1:0]    record_id,
	output logic [SAL_W-1:0]   record_salary,
	output logic [DEP_W-1:0]   record_department,
	output logic [ENTRY_W-1:0] entry_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_READ = 3'b100
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [ID_W-1:0] last_id_q;

	// scan request operands, held for the whole pass
	logic             is_upd_q;
	logic [ID_W-1:0]  key_q;
	logic [SAL_W-1:0] sal_q;
	logic [DEP_W-1:0] dep_q;
	logic [CW-1:0]    rd_ptr_q;
	logic             hit_q;

	// read stage: the entry whose data is on the RAM output this cycle
	logic             valid_s1;
	logic [AW-1:0]    addr_s1;

	logic             done_q;
	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0]  rid_q;
	logic [SAL_W-1:0] rsal_q;
	logic [DEP_W-1:0] rdep_q;
	logic [ENTRY_W-1:0] ecnt_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	record_t       ram_wdata;
	logic [AW-1:0] ram_raddr;
	record_t       ram_rdata;

	logic accept;
	logic load_bad_id;
	logic tbl_full;
	logic add_id_exh;
	logic slot_bad;
	logic key_match;
	logic scan_last;
	logic scan_hit;
	logic issue;

	krt_ram #(
		.WIDTH (REC_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign load_bad_id = (key_id == '0) || (32'(key_id) > 32'(TABLE_DEPTH));
	assign tbl_full    = (32'(cnt_q) >= 32'(TABLE_DEPTH));
	assign add_id_exh  = (last_id_q == ID_MAX);
	assign slot_bad    = (32'(slot_index) >= 32'(cnt_q));

	assign issue     = (rd_ptr_q < cnt_q);
	assign key_match = valid_s1 && (ram_rdata.id == key_q);
	assign scan_last = valid_s1 && (CW'(addr_s1) == cnt_q - 1'b1);
	assign scan_hit  = hit_q || key_match;

	// RAM port steering: direct writes for load/add, rewrites and moves during a scan
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = '{id: last_id_q + 1'b1, salary: salary_in, dept: department_in};
		ram_raddr = rd_ptr_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				ram_raddr = AW'(slot_index);
				if (accept && kind == KIND_LOAD && !load_bad_id && !tbl_full) begin
					ram_we         = 1'b1;
					ram_waddr      = AW'(key_id - 1'b1);
					ram_wdata.id   = key_id;
				end else if (accept && kind == KIND_ADD && !tbl_full && !add_id_exh) begin
					ram_we = 1'b1;
				end
			end
			S_SCAN: begin
				if (is_upd_q) begin
					// rewrite salary and department of every match, keep the ID
					ram_we    = key_match;
					ram_waddr = addr_s1;
					ram_wdata = '{id: ram_rdata.id, salary: sal_q, dept: dep_q};
				end else begin
					// once the first match is passed, move each entry down one slot
					ram_we    = valid_s1 && hit_q;
					ram_waddr = addr_s1 - 1'b1;
					ram_wdata = ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	// control: state, count, last ID, scan pointer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			last_id_q <= '0;
			rd_ptr_q  <= '0;
			valid_s1  <= 1'b0;
			hit_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_ptr_q <= '0;
						valid_s1 <= 1'b0;
						hit_q    <= 1'b0;
						case (kind)
							KIND_LOAD: begin
								done_q <= 1'b1;
								if (!load_bad_id && !tbl_full) begin
									cnt_q <= cnt_q + 1'b1;
									if (!add_id_exh) begin
										last_id_q <= last_id_q + 1'b1;
									end
								end
							end
							KIND_ADD: begin
								done_q <= 1'b1;
								if (!tbl_full && !add_id_exh) begin
									cnt_q     <= cnt_q + 1'b1;
									last_id_q <= last_id_q + 1'b1;
								end
							end
							KIND_UPDATE, KIND_DELETE: begin
								if (cnt_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							KIND_READ: begin
								if (slot_bad) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					valid_s1 <= issue;
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (key_match) begin
						hit_q <= 1'b1;
					end
					if (scan_last) begin
						state_q  <= S_IDLE;
						valid_s1 <= 1'b0;
						done_q   <= 1'b1;
						if (!is_upd_q && scan_hit) begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: request operands, read-stage address and result fields
	always_ff @(posedge clk) begin
		addr_s1 <= rd_ptr_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				is_upd_q <= (kind == KIND_UPDATE);
				key_q    <= key_id;
				sal_q    <= salary_in;
				dep_q    <= department_in;
				status_q <= ST_OK;
				rid_q    <= '0;
				rsal_q   <= '0;
				rdep_q   <= '0;
				ecnt_q   <= ENTRY_W'(cnt_q);
				case (kind)
					KIND_LOAD: begin
						if (load_bad_id) begin
							status_q <= ST_BAD_ID;
						end else if (tbl_full) begin
							status_q <= ST_FULL;
						end else begin
							ecnt_q <= ENTRY_W'(cnt_q + 1'b1);
						end
					end
					KIND_ADD: begin
						if (tbl_full) begin
							status_q <= ST_FULL;
						end else if (add_id_exh) begin
							status_q <= ST_BAD_ID;
						end else begin
							rid_q  <= last_id_q + 1'b1;
							ecnt_q <= ENTRY_W'(cnt_q + 1'b1);
						end
					end
					KIND_UPDATE: begin
						status_q <= ST_BAD_ID;
					end
					KIND_DELETE: begin
						status_q <= ST_EMPTY;
					end
					KIND_READ: begin
						status_q <= ST_BAD_SLOT;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				status_q <= scan_hit ? ST_OK : ST_BAD_ID;
				if (!is_upd_q && scan_hit) begin
					ecnt_q <= ENTRY_W'(cnt_q - 1'b1);
				end
			end
			S_READ: begin
				status_q <= ST_OK;
				rid_q    <= ram_rdata.id;
				rsal_q   <= ram_rdata.salary;
				rdep_q   <= ram_rdata.dept;
			end
			default: begin
			end
		endcase
	end

	assign done              = done_q;
	assign status            = status_q;
	assign record_id         = rid_q;
	assign record_salary     = rsal_q;
	assign record_department = rdep_q;
	assign entry_count       = ecnt_q;

`include "keyed_record_table_assert.svh"

	`KRT_ASSERT_NOW(a_cnt_bound, 1'b1, 32'(cnt_q) <= 32'(TABLE_DEPTH),
		"record count exceeds table depth")
	`KRT_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE,
		"result strobe while a request is still in progress")
	`KRT_ASSERT_NOW(a_scan_wr, (state_q == S_SCAN) && ram_we, valid_s1,
		"scan writes the table without read data in hand")
	`KRT_ASSERT_NEXT(a_cnt_step, state_q == S_SCAN,
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) - 1'b1),
		"scan changed the count by more than one removal")

endmodule

[design/krt_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module krt_ram import krt_pkg::*; #(
	parameter int WIDTH = REC_W,
	parameter int DEPTH = KRT_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[tb/krt_ledger_pkg.sv]
// Request and reply types, plus the scoreboard class that predicts and checks record table replies.
`timescale 1ns / 1ps

package krt_ledger_pkg;
	import krt_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		record_t           rec;
		logic [SLOT_W-1:0] slot;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		record_t            rec;
		logic [ENTRY_W-1:0] count;
	} reply_t;

	class record_ledger;
		int unsigned     depth;
		record_t         rows[];
		bit              written[];
		int unsigned     held;
		logic [ID_W-1:0] last_id;
		reply_t          pending[$];
		int unsigned     tally[8];
		int unsigned     peak_held;
		int unsigned     replies_seen;
		int unsigned     mismatches;

		function new(int unsigned table_depth);
			depth = table_depth;
			rows = new[table_depth];
			written = new[table_depth];
			held = 0;
			last_id = '0;
			peak_held = 0;
			replies_seen = 0;
			mismatches = 0;
			foreach (tally[k]) tally[k] = 0;
		endfunction

		// True when some slot below the count was never written.
		function bit has_gap();
			for (int unsigned i = 0; i < held; i++)
				if (!written[i]) return 1'b1;
			return 1'b0;
		endfunction

		// Apply one accepted request to the mirrored table and queue its reply.
		function void note_request(request_t req);
			reply_t      r;
			int unsigned pos;
			bit          hit;
			r = '0;
			r.status = ST_OK;
			tally[req.kind]++;
			case (req.kind)
			KIND_LOAD: begin
				if (req.rec.id == '0 || req.rec.id > depth) begin
					r.status = ST_BAD_ID;
				end else if (held >= depth) begin
					r.status = ST_FULL;
				end else begin
					rows[req.rec.id - 1] = req.rec;
					written[req.rec.id - 1] = 1'b1;
					held++;
					if (last_id != ID_MAX) last_id++;
				end
			end
			KIND_ADD: begin
				if (held >= depth) begin
					r.status = ST_FULL;
				end else if (last_id == ID_MAX) begin
					r.status = ST_BAD_ID;
				end else begin
					last_id++;
					rows[held] = '{id: last_id, salary: req.rec.salary, dept: req.rec.dept};
					written[held] = 1'b1;
					held++;
					r.rec.id = last_id;
				end
			end
			KIND_UPDATE: begin
				hit = 1'b0;
				for (int unsigned i = 0; i < held; i++) begin
					if (rows[i].id == req.rec.id) begin
						rows[i].salary = req.rec.salary;
						rows[i].dept = req.rec.dept;
						hit = 1'b1;
					end
				end
				if (!hit) r.status = ST_BAD_ID;
			end
			KIND_DELETE: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pos = held;
					for (int unsigned i = 0; i < held; i++) begin
						if (rows[i].id == req.rec.id) begin
							pos = i;
							break;
						end
					end
					if (pos == held) begin
						r.status = ST_BAD_ID;
					end else begin
						for (int unsigned i = pos; i + 1 < held; i++) begin
							rows[i] = rows[i + 1];
							written[i] = written[i + 1];
						end
						held--;
					end
				end
			end
			KIND_READ: begin
				if (req.slot >= held) r.status = ST_BAD_SLOT;
				else r.rec = rows[req.slot];
			end
			default: ;
			endcase
			r.count = ENTRY_W'(held);
			if (held > peak_held) peak_held = held;
			pending.push_back(r);
		endfunction

		// Compare one observed reply with the oldest queued one.
		function void compare_reply(reply_t got);
			reply_t want;
			replies_seen++;
			if (pending.size() == 0) begin
				$error("reply with no request outstanding: status %0d, entry_count %0d",
					got.status, got.count);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.rec.id !== want.rec.id) begin
				$error("record_id: expected %0d, got %0d", want.rec.id, got.rec.id);
				mismatches++;
			end
			if (got.rec.salary !== want.rec.salary) begin
				$error("record_salary: expected %0d, got %0d", want.rec.salary, got.rec.salary);
				mismatches++;
			end
			if (got.rec.dept !== want.rec.dept) begin
				$error("record_department: expected %0d, got %0d", want.rec.dept, got.rec.dept);
				mismatches++;
			end
			if (got.count !== want.count) begin
				$error("entry_count: expected %0d, got %0d", want.count, got.count);
				mismatches++;
			end
		endfunction
	endclass

endpackage

[tb/tb_keyed_record_table.sv]
// Testbench top: drives the record table with directed and random requests and checks every reply.
`timescale 1ns / 1ps

module tb_keyed_record_table;
	import krt_pkg::*;
	import krt_ledger_pkg::*;

	localparam int DEPTH = KRT_DEPTH_DEFAULT;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned CROWDED = 40;   // above this, steer growth toward deletes
	localparam int unsigned PHASE_ITEMS = 60;
	localparam int unsigned TAIL_ITEMS = 24;
	localparam logic [KIND_W-1:0] KIND_FIRST_SPARE = 3'd5;
	localparam logic [KIND_W-1:0] KIND_LAST_SPARE  = 3'd7;
	localparam logic [SAL_W-1:0] SAL_TOP = '1;
	localparam logic [DEP_W-1:0] DEP_TOP = '1;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [KIND_W-1:0]  kind;
	logic [ID_W-1:0]    key_id;
	logic [SAL_W-1:0]   salary_in;
	logic [DEP_W-1:0]   department_in;
	logic [SLOT_W-1:0]  slot_index;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [ID_W-1:0]    record_id;
	logic [SAL_W-1:0]   record_salary;
	logic [DEP_W-1:0]   record_department;
	logic [ENTRY_W-1:0] entry_count;

	record_ledger ledger = new(DEPTH);
	int unsigned  sender_idle_pct = 0;
	int unsigned  cycles = 0;
	int unsigned  phase_idle[4] = '{0, 83, 0, 12};
	reply_t       observed;

	keyed_record_table #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.key_id           (key_id),
		.salary_in        (salary_in),
		.department_in    (department_in),
		.slot_index       (slot_index),
		.done             (done),
		.status           (status),
		.record_id        (record_id),
		.record_salary    (record_salary),
		.record_department(record_department),
		.entry_count      (entry_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Hard stop in case the block hangs or drops a reply.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Sample the reply on the edge that ends its done cycle; the receiver never stalls.
	always @(posedge clk) begin
		if (arst_n && done) begin
			observed = '{status: status,
				rec: '{id: record_id, salary: record_salary, dept: record_department},
				count: entry_count};
			ledger.compare_reply(observed);
		end
	end

	// Random operand values at the width of each field.
	function automatic logic [ID_W-1:0] rnd_key();
		return ID_W'($urandom);
	endfunction

	function automatic logic [SAL_W-1:0] rnd_sal();
		return SAL_W'($urandom);
	endfunction

	function automatic logic [DEP_W-1:0] rnd_dep();
		return DEP_W'($urandom);
	endfunction

	function automatic logic [SLOT_W-1:0] rnd_slot();
		return SLOT_W'($urandom);
	endfunction

	// Present one request and hold it until the block takes it (start high, busy low
	// at the edge). Idle the sender first, at the phase's rate, so gaps land both
	// while the block is free and while it is still scanning the previous request.
	task automatic send_request(input logic [KIND_W-1:0] op, input logic [ID_W-1:0] key,
		input logic [SAL_W-1:0] sal, input logic [DEP_W-1:0] dep,
		input logic [SLOT_W-1:0] pos);
		request_t req;
		req = '{kind: op, rec: '{id: key, salary: sal, dept: dep}, slot: pos};
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		start <= 1'b1;
		kind <= op;
		key_id <= key;
		salary_in <= sal;
		department_in <= dep;
		slot_index <= pos;
		do @(posedge clk); while (busy);
		ledger.note_request(req);
	endtask

	// One random request. Most traffic is well formed: loads at the next free slot,
	// updates and deletes of IDs that are held, reads of held slots. The rest is noise:
	// unknown IDs, out-of-range slots, bad load keys and spare kinds.
	// Never let a scan or a read touch a slot that was never written; loads that
	// would open such a hole below the count are allowed only when asked for.
	task automatic issue_random_request(input bit allow_gaps);
		logic [KIND_W-1:0] op;
		logic [ID_W-1:0]   key;
		logic [SAL_W-1:0]  sal;
		logic [DEP_W-1:0]  dep;
		logic [SLOT_W-1:0] pos;
		int unsigned       pick;
		int unsigned       held;
		bit                gap;
		held = ledger.held;
		gap = ledger.has_gap();
		key = rnd_key();
		sal = rnd_sal();
		dep = rnd_dep();
		pos = rnd_slot();
		pick = $urandom_range(99);
		if (held > CROWDED && pick < 36 && $urandom_range(1) == 1) pick = 60;
		if (gap && pick >= 36 && pick < 73) pick = 0;
		if (pick < 22) begin
			op = KIND_ADD;
		end else if (pick < 36) begin
			op = KIND_LOAD;
			if (held < DEPTH) begin
				key = ID_W'(held + 1);
				// A load elsewhere keeps the table dense only if the slot at the
				// count already holds a record (left behind by a delete).
				if ((allow_gaps || ledger.written[held]) && $urandom_range(2) == 0)
					key = ID_W'($urandom_range(DEPTH, 1));
			end else begin
				key = ID_W'($urandom_range(DEPTH, 1));
			end
		end else if (pick < 73) begin
			op = (pick < 55) ? KIND_UPDATE : KIND_DELETE;
			if (held != 0 && $urandom_range(3) != 0)
				key = ledger.rows[$urandom_range(held - 1)].id;
		end else if (pick < 93) begin
			op = KIND_READ;
			if (held != 0 && $urandom_range(4) != 0) pos = SLOT_W'($urandom_range(held - 1));
			if (pos < held && !ledger.written[pos]) op = KIND_ADD;
		end else if (pick < 97) begin
			op = KIND_LOAD;
			if ($urandom_range(1) == 1) key = '0;
			else key = ID_W'($urandom_range(32'(ID_MAX), DEPTH + 1));
		end else begin
			op = KIND_W'($urandom_range(int'(KIND_LAST_SPARE), int'(KIND_FIRST_SPARE)));
		end
		send_request(op, key, sal, dep, pos);
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= KIND_LOAD;
		key_id <= '0;
		salary_in <= '0;
		department_in <= '0;
		slot_index <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-table errors, bad load keys, spare kinds.
		send_request(KIND_READ, rnd_key(), rnd_sal(), rnd_dep(), '0);
		send_request(KIND_DELETE, ID_W'(1), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_UPDATE, ID_W'(1), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_LOAD, '0, rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_LOAD, ID_MAX, rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_LOAD, ID_W'(DEPTH + 1), rnd_sal(), rnd_dep(), rnd_slot());
		for (int k = int'(KIND_FIRST_SPARE); k <= int'(KIND_LAST_SPARE); k++)
			send_request(KIND_W'(k), rnd_key(), rnd_sal(), rnd_dep(), rnd_slot());

		// Build a few records with extreme payloads; adds continue from loaded IDs.
		send_request(KIND_LOAD, ID_W'(1), SAL_TOP, DEP_TOP, '1);
		send_request(KIND_ADD, ID_MAX, '0, '0, '0);
		send_request(KIND_ADD, '0, SAL_TOP, DEP_TOP, '0);
		send_request(KIND_LOAD, ID_W'(4), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_ADD, rnd_key(), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_READ, rnd_key(), rnd_sal(), rnd_dep(), '0);
		send_request(KIND_READ, rnd_key(), rnd_sal(), rnd_dep(), SLOT_W'(4));
		send_request(KIND_READ, rnd_key(), rnd_sal(), rnd_dep(), SLOT_W'(5));
		send_request(KIND_READ, rnd_key(), rnd_sal(), rnd_dep(), '1);
		send_request(KIND_UPDATE, ID_W'(2), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_UPDATE, ID_W'(99), rnd_sal(), rnd_dep(), rnd_slot());

		// Duplicates: delete the head, then reload ID 2 over slot 1. The count
		// re-covers the stale tail, so IDs 2 and 5 both appear twice.
		send_request(KIND_DELETE, ID_W'(1), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_LOAD, ID_W'(2), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_UPDATE, ID_W'(2), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_DELETE, ID_W'(2), rnd_sal(), rnd_dep(), rnd_slot());
		send_request(KIND_READ, rnd_key(), rnd_sal(), rnd_dep(), '0);
		send_request(KIND_DELETE, ID_W'(5), rnd_sal(), rnd_dep(), rnd_slot());

		// Random phases, each with its own sender idle rate.
		foreach (phase_idle[p]) begin
			sender_idle_pct = phase_idle[p];
			repeat (PHASE_ITEMS) issue_random_request(1'b0);
		end

		// Tail: sparse traffic with loads anywhere, holes below the count allowed.
		sender_idle_pct = 83;
		repeat (TAIL_ITEMS) issue_random_request(1'b1);

		// Drain: wait out every pending reply, then a full scan's worth of cycles
		// to catch a stray done.
		start <= 1'b0;
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		$display("Checked %0d replies: %0d loads, %0d adds, %0d updates, %0d deletes, %0d reads.",
			ledger.replies_seen, ledger.tally[KIND_LOAD], ledger.tally[KIND_ADD],
			ledger.tally[KIND_UPDATE], ledger.tally[KIND_DELETE], ledger.tally[KIND_READ]);
		$display("Table held up to %0d of %0d records; %0d field mismatches.",
			ledger.peak_held, DEPTH, ledger.mismatches);
		if (ledger.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[keyed_record_table.f]
+incdir+design
design/krt_pkg.sv
design/krt_ram.sv
design/keyed_record_table.sv
tb/krt_ledger_pkg.sv
tb/tb_keyed_record_table.sv
